>>> sv/rhrt_pkg.sv
// shared types, widths and constants of the rgb to hsv range threshold unit
package rhrt_pkg;

    localparam int unsigned COMP_W    = 8;
    localparam int unsigned HUE_W     = 9;
    localparam int unsigned PCT_W     = 7;
    localparam int unsigned SIX_W     = 11;
    localparam int unsigned REM_W     = 17;
    localparam int unsigned Q_W       = 9;
    localparam int unsigned CFG_W     = 10;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned NUM_STAGES = Q_W + 3;

    localparam logic [HUE_W:0] HUE_WRAP = 10'd360;

    localparam logic signed [9:0] HUE_LOW_RST  = -10'sd1;
    localparam logic [8:0]        HUE_HIGH_RST = 9'd361;
    localparam logic signed [7:0] SAT_LOW_RST  = -8'sd1;
    localparam logic [6:0]        SAT_HIGH_RST = 7'd101;
    localparam logic signed [7:0] VAL_LOW_RST  = -8'sd1;
    localparam logic [6:0]        VAL_HIGH_RST = 7'd101;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HUE_LOW  = 3'd0,
        CFG_HUE_HIGH = 3'd1,
        CFG_SAT_LOW  = 3'd2,
        CFG_SAT_HIGH = 3'd3,
        CFG_VAL_LOW  = 3'd4,
        CFG_VAL_HIGH = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic signed [9:0] hue_low;
        logic [8:0]        hue_high;
        logic signed [7:0] sat_low;
        logic [6:0]        sat_high;
        logic signed [7:0] val_low;
        logic [6:0]        val_high;
    } t_bounds;

    typedef struct packed {
        logic              grey;
        logic [COMP_W-1:0] mx;
        logic [COMP_W-1:0] d;
        logic [SIX_W-1:0]  sixths;
    } t_prep;

    typedef struct packed {
        logic              grey;
        logic [REM_W-1:0]  hue_rem;
        logic [COMP_W-1:0] hue_div;
        logic [Q_W-1:0]    hue_q;
        logic [REM_W-1:0]  sat_rem;
        logic [COMP_W-1:0] sat_div;
        logic [Q_W-1:0]    sat_q;
        logic [PCT_W-1:0]  val;
    } t_lane;

    typedef struct packed {
        logic             in_range;
        logic [HUE_W-1:0] hue_deg;
        logic [PCT_W-1:0] sat_pct;
        logic [PCT_W-1:0] val_pct;
    } t_result;

endpackage

>>> sv/rhrt_prep.sv
// first stage: max, min, spread and hue in sixths of the spread
module rhrt_prep import rhrt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_load,
    input  logic [COMP_W-1:0] i_red,
    input  logic [COMP_W-1:0] i_green,
    input  logic [COMP_W-1:0] i_blue,
    output t_prep             o_prep
);

    logic [COMP_W-1:0] n_mx;
    logic [COMP_W-1:0] n_mn;
    logic [COMP_W-1:0] n_d;
    logic signed [11:0] n_t;
    logic signed [11:0] n_six_d;
    logic signed [11:0] n_sum;
    logic               red_max;
    logic               green_max;
    t_prep              r_prep;

    always_comb begin
        red_max   = (i_red >= i_green) && (i_red >= i_blue);
        green_max = !red_max && (i_green >= i_blue);
        n_mx = i_red;
        if (i_green > n_mx) n_mx = i_green;
        if (i_blue > n_mx) n_mx = i_blue;
        n_mn = i_red;
        if (i_green < n_mn) n_mn = i_green;
        if (i_blue < n_mn) n_mn = i_blue;
        n_d = n_mx - n_mn;
        n_six_d = $signed(({4'b0, n_d} << 2) + ({4'b0, n_d} << 1));
        priority if (red_max) begin
            n_t = $signed({4'b0, i_green}) - $signed({4'b0, i_blue});
        end else if (green_max) begin
            n_t = $signed({3'b0, n_d, 1'b0}) + $signed({4'b0, i_blue})
                - $signed({4'b0, i_red});
        end else begin
            n_t = $signed({2'b0, n_d, 2'b0}) + $signed({4'b0, i_red})
                - $signed({4'b0, i_green});
        end
        n_sum = (n_t < 0) ? (n_t + n_six_d) : n_t;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prep.grey   <= (n_d == '0);
            r_prep.mx     <= n_mx;
            r_prep.d      <= n_d;
            r_prep.sixths <= n_sum[SIX_W-1:0];
        end
    end

    assign o_prep = r_prep;

endmodule

>>> sv/rhrt_scale.sv
// second stage: division numerators and rounded value percent
module rhrt_scale import rhrt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_load,
    input  t_prep i_prep,
    output t_lane o_lane
);

    logic [15:0] n_vnum;
    logic [15:0] n_vq;
    t_lane       r_lane;

    always_comb begin
        // round(mx * 100 / 255) as floor((mx * 100 + 127) / 255), reciprocal form
        n_vnum = 16'({8'b0, i_prep.mx} * 16'd100) + 16'd127;
        n_vq   = (n_vnum + (n_vnum >> 8) + 16'd1) >> 8;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_lane.grey    <= i_prep.grey;
            r_lane.hue_rem <= REM_W'({6'b0, i_prep.sixths} * 17'd60);
            r_lane.hue_div <= i_prep.d;
            r_lane.hue_q   <= '0;
            r_lane.sat_rem <= REM_W'({9'b0, i_prep.d} * 17'd100);
            r_lane.sat_div <= i_prep.mx;
            r_lane.sat_q   <= '0;
            r_lane.val     <= n_vq[PCT_W-1:0];
        end
    end

    assign o_lane = r_lane;

endmodule

>>> sv/rhrt_div_cell.sv
// one restoring division cell: settles one quotient bit of hue and saturation
module rhrt_div_cell import rhrt_pkg::*; #(
    parameter int unsigned BIT = 0
) (
    input  logic  i_clk,
    input  logic  i_load,
    input  t_lane i_lane,
    output t_lane o_lane
);

    logic [REM_W-1:0] hue_trial;
    logic [REM_W-1:0] sat_trial;
    logic             hue_ge;
    logic             sat_ge;
    t_lane            n_lane;
    t_lane            r_lane;

    always_comb begin
        hue_trial = REM_W'({9'b0, i_lane.hue_div} << BIT);
        sat_trial = REM_W'({9'b0, i_lane.sat_div} << BIT);
        hue_ge    = i_lane.hue_rem >= hue_trial;
        sat_ge    = i_lane.sat_rem >= sat_trial;
        n_lane    = i_lane;
        if (hue_ge) n_lane.hue_rem = i_lane.hue_rem - hue_trial;
        if (sat_ge) n_lane.sat_rem = i_lane.sat_rem - sat_trial;
        n_lane.hue_q[BIT] = hue_ge;
        n_lane.sat_q[BIT] = sat_ge;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

>>> sv/rhrt_round.sv
// last stage: round half to even, wrap hue, bound test, output register
module rhrt_round import rhrt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_load,
    input  t_lane   i_lane,
    input  t_bounds i_bounds,
    output t_result o_result
);

    logic [9:0]       hue_twice;
    logic [9:0]       sat_twice;
    logic             hue_up;
    logic             sat_up;
    logic [HUE_W:0]   hue_sum;
    logic [Q_W:0]     sat_sum;
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] sat;
    t_result          n_result;
    t_result          r_result;

    always_comb begin
        // remainder is below the divisor here, so nine bits hold it
        hue_twice = {i_lane.hue_rem[8:0], 1'b0};
        sat_twice = {i_lane.sat_rem[8:0], 1'b0};
        hue_up = (hue_twice > {2'b0, i_lane.hue_div})
              || ((hue_twice == {2'b0, i_lane.hue_div}) && i_lane.hue_q[0]);
        sat_up = (sat_twice > {2'b0, i_lane.sat_div})
              || ((sat_twice == {2'b0, i_lane.sat_div}) && i_lane.sat_q[0]);
        hue_sum = {1'b0, i_lane.hue_q} + {{HUE_W{1'b0}}, hue_up};
        sat_sum = {1'b0, i_lane.sat_q} + {{Q_W{1'b0}}, sat_up};
        if (i_lane.grey) begin
            hue = '0;
            sat = '0;
        end else begin
            hue = (hue_sum >= HUE_WRAP) ? HUE_W'(hue_sum - HUE_WRAP) : hue_sum[HUE_W-1:0];
            sat = sat_sum[PCT_W-1:0];
        end
        n_result.hue_deg = hue;
        n_result.sat_pct = sat;
        n_result.val_pct = i_lane.val;
        n_result.in_range =
               (i_bounds.hue_low < $signed({1'b0, hue}))
            && (hue < i_bounds.hue_high)
            && (i_bounds.sat_low < $signed({1'b0, sat}))
            && (sat < i_bounds.sat_high)
            && (i_bounds.val_low < $signed({1'b0, i_lane.val}))
            && (i_lane.val < i_bounds.val_high);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule

>>> sv/rgb_hsv_range_threshold_unit.sv
// top level of the rgb to hsv range threshold unit
//
// Converts one 8-bit RGB pixel per transaction to HSV (hue in degrees 0..359,
// saturation and value in percent 0..100, rounded half to even) and flags the
// pixel when all three lie strictly inside the programmed bounds.
// Input channel: i_valid / o_stall with i_red_in, i_green_in, i_blue_in.
// Output channel: o_valid / i_stall with o_in_range, o_hue_deg, o_sat_pct,
// o_val_pct; exactly one result per pixel, in order.
// A pixel passes from the accepting edge to o_valid through twelve
// register stages: a prep stage, a scale stage, nine division cells (one
// quotient bit each for hue and saturation) and a rounding stage that holds
// the output register.
// Throughput is one pixel per cycle unless i_stall holds it; every stage has
// its own valid bit, so a stall only holds up full stages; bubbles close up.
// When the receiver stalls, the result stays on the output unchanged and the
// pipeline keeps filling until full, then o_stall rises. Reset clears all
// valid bits and sets the bounds so every pixel is in range. Bounds are set
// via i_cfg_wr_en / i_cfg_index / i_cfg_data by the user only while no
// transaction is in flight, unchecked here; unknown indexes are ignored.
module rgb_hsv_range_threshold_unit import rhrt_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [COMP_W-1:0]    i_red_in,
    input  logic [COMP_W-1:0]    i_green_in,
    input  logic [COMP_W-1:0]    i_blue_in,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_in_range,
    output logic [HUE_W-1:0]     o_hue_deg,
    output logic [PCT_W-1:0]     o_sat_pct,
    output logic [PCT_W-1:0]     o_val_pct,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] n_vld;
    logic [NUM_STAGES:0]   w_rdy;
    logic [NUM_STAGES-1:0] w_src_vld;
    logic [NUM_STAGES-1:0] w_load;
    t_bounds               r_bounds;
    t_prep                 w_prep;
    t_lane                 w_lane [Q_W+1];
    t_result               w_result;

    // per-stage handshake
    assign w_rdy[NUM_STAGES] = !i_stall;
    assign w_src_vld[0]      = i_valid;

    genvar k;
    generate
        for (k = 0; k < NUM_STAGES; k++) begin : g_ctl
            assign w_rdy[k]  = !r_vld[k] || w_rdy[k+1];
            assign w_load[k] = w_rdy[k] && w_src_vld[k];
            assign n_vld[k]  = w_rdy[k] ? w_src_vld[k] : r_vld[k];
            if (k > 0) begin : g_src
                assign w_src_vld[k] = r_vld[k-1];
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // bound registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bounds.hue_low  <= HUE_LOW_RST;
            r_bounds.hue_high <= HUE_HIGH_RST;
            r_bounds.sat_low  <= SAT_LOW_RST;
            r_bounds.sat_high <= SAT_HIGH_RST;
            r_bounds.val_low  <= VAL_LOW_RST;
            r_bounds.val_high <= VAL_HIGH_RST;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_HUE_LOW:  r_bounds.hue_low  <= $signed(i_cfg_data);
                CFG_HUE_HIGH: r_bounds.hue_high <= i_cfg_data[8:0];
                CFG_SAT_LOW:  r_bounds.sat_low  <= $signed(i_cfg_data[7:0]);
                CFG_SAT_HIGH: r_bounds.sat_high <= i_cfg_data[6:0];
                CFG_VAL_LOW:  r_bounds.val_low  <= $signed(i_cfg_data[7:0]);
                CFG_VAL_HIGH: r_bounds.val_high <= i_cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    rhrt_prep u_prep (
        .i_clk   (i_clk),
        .i_load  (w_load[0]),
        .i_red   (i_red_in),
        .i_green (i_green_in),
        .i_blue  (i_blue_in),
        .o_prep  (w_prep)
    );

    rhrt_scale u_scale (
        .i_clk  (i_clk),
        .i_load (w_load[1]),
        .i_prep (w_prep),
        .o_lane (w_lane[0])
    );

    generate
        for (k = 0; k < Q_W; k++) begin : g_cell
            rhrt_div_cell #(
                .BIT (Q_W - 1 - k)
            ) u_cell (
                .i_clk  (i_clk),
                .i_load (w_load[k+2]),
                .i_lane (w_lane[k]),
                .o_lane (w_lane[k+1])
            );
        end
    endgenerate

    rhrt_round u_round (
        .i_clk    (i_clk),
        .i_load   (w_load[NUM_STAGES-1]),
        .i_lane   (w_lane[Q_W]),
        .i_bounds (r_bounds),
        .o_result (w_result)
    );

    assign o_stall    = !w_rdy[0];
    assign o_valid    = r_vld[NUM_STAGES-1];
    assign o_in_range = w_result.in_range;
    assign o_hue_deg  = w_result.hue_deg;
    assign o_sat_pct  = w_result.sat_pct;
    assign o_val_pct  = w_result.val_pct;

    a_hue_wrapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({1'b0, o_hue_deg} < HUE_WRAP))
        else $error("hue not wrapped below 360");

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_sat_pct <= 7'd100) && (o_val_pct <= 7'd100))
        else $error("percent out of range");

    a_no_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while output register empty");

    a_in_range_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_in_range) |-> (o_hue_deg < r_bounds.hue_high))
        else $error("in range flag with hue above bound");

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// self-checking testbench of the rgb to hsv range threshold unit
module tb;
    import rhrt_pkg::*;

    localparam int unsigned HALF_PERIOD   = 5;
    localparam int unsigned RESET_CYCLES  = 5;
    localparam int unsigned PHASE_PIXELS  = 100;
    localparam int unsigned HOLD_CYCLES   = 80;
    localparam int unsigned SETTLE_CYCLES = NUM_STAGES + 4;
    localparam int unsigned DRAIN_LIMIT   = 20000;
    localparam int unsigned REPORT_LIMIT  = 100;
    localparam int unsigned TIMEOUT_NS    = 5_000_000;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

    typedef enum {BND_RESET, BND_OPEN, BND_CLOSED, BND_WINDOW, BND_ANY} t_bound_plan;

    typedef struct {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
        bit                typed;
        t_result           res;
    } t_pixel_row;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_stall;
    logic [COMP_W-1:0]    i_red_in    = '0;
    logic [COMP_W-1:0]    i_green_in  = '0;
    logic [COMP_W-1:0]    i_blue_in   = '0;
    logic                 o_valid;
    logic                 i_stall     = 1'b0;
    logic                 o_in_range;
    logic [HUE_W-1:0]     o_hue_deg;
    logic [PCT_W-1:0]     o_sat_pct;
    logic [PCT_W-1:0]     o_val_pct;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    t_bounds     limits = '{HUE_LOW_RST, HUE_HIGH_RST, SAT_LOW_RST, SAT_HIGH_RST,
                            VAL_LOW_RST, VAL_HIGH_RST};
    t_result     pending_hsv[$];
    int unsigned mismatch_count = 0;
    int unsigned tx_burst_left  = 0;
    int unsigned rx_stall_left  = 0;
    int unsigned rx_free_left   = 0;
    bit          hold_req       = 1'b0;

    t_bound_plan plan[9] = '{BND_RESET, BND_OPEN, BND_CLOSED, BND_WINDOW, BND_WINDOW,
                             BND_WINDOW, BND_WINDOW, BND_WINDOW, BND_ANY};

    t_pixel_row directed_rows[24] = '{
        '{8'd0,   8'd0,   8'd0,   1'b1, '{1'b1, 9'd0,   7'd0,   7'd0}},
        '{8'd255, 8'd255, 8'd255, 1'b1, '{1'b1, 9'd0,   7'd0,   7'd100}},
        '{8'd255, 8'd0,   8'd0,   1'b1, '{1'b1, 9'd0,   7'd100, 7'd100}},
        '{8'd0,   8'd255, 8'd0,   1'b1, '{1'b1, 9'd120, 7'd100, 7'd100}},
        '{8'd0,   8'd0,   8'd255, 1'b1, '{1'b1, 9'd240, 7'd100, 7'd100}},
        '{8'd255, 8'd255, 8'd0,   1'b1, '{1'b1, 9'd60,  7'd100, 7'd100}},
        '{8'd0,   8'd255, 8'd255, 1'b1, '{1'b1, 9'd180, 7'd100, 7'd100}},
        '{8'd255, 8'd0,   8'd255, 1'b1, '{1'b1, 9'd300, 7'd100, 7'd100}},
        // negative hue that rounds up to 360 and wraps
        '{8'd255, 8'd0,   8'd1,   1'b1, '{1'b1, 9'd0,   7'd100, 7'd100}},
        '{8'd128, 8'd128, 8'd128, 1'b1, '{1'b1, 9'd0,   7'd0,   7'd50}},
        '{8'd1,   8'd1,   8'd1,   1'b1, '{1'b1, 9'd0,   7'd0,   7'd0}},
        '{8'd1,   8'd0,   8'd0,   1'b1, '{1'b1, 9'd0,   7'd100, 7'd0}},
        '{8'd255, 8'd0,   8'd128, 1'b0, '0},
        // hue ties, rounded to even
        '{8'd8,   8'd1,   8'd0,   1'b0, '0},
        '{8'd16,  8'd6,   8'd0,   1'b0, '0},
        // saturation ties
        '{8'd200, 8'd199, 8'd199, 1'b0, '0},
        '{8'd200, 8'd197, 8'd197, 1'b0, '0},
        // shared maximum, first one wins
        '{8'd200, 8'd200, 8'd100, 1'b0, '0},
        '{8'd100, 8'd200, 8'd200, 1'b0, '0},
        '{8'd200, 8'd100, 8'd200, 1'b0, '0},
        '{8'd254, 8'd255, 8'd254, 1'b0, '0},
        '{8'd0,   8'd1,   8'd255, 1'b0, '0},
        '{8'd170, 8'd85,  8'd255, 1'b0, '0},
        '{8'd255, 8'd254, 8'd0,   1'b0, '0}
    };

    rgb_hsv_range_threshold_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_red_in    (i_red_in),
        .i_green_in  (i_green_in),
        .i_blue_in   (i_blue_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_in_range  (o_in_range),
        .o_hue_deg   (o_hue_deg),
        .o_sat_pct   (o_sat_pct),
        .o_val_pct   (o_val_pct),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic int round_half_even(input int num, input int den);
        int quo;
        int rem;
        quo = num / den;
        rem = num % den;
        if (2 * rem > den || (2 * rem == den && quo % 2 == 1)) begin
            quo++;
        end
        return quo;
    endfunction

    function automatic t_result pixel_to_hsv(input logic [COMP_W-1:0] r, g, b);
        int red;
        int grn;
        int blu;
        int mx;
        int mn;
        int d;
        int num;
        int hue;
        int sat;
        int val;
        t_result res;
        red = r;
        grn = g;
        blu = b;
        mx = red;
        mn = red;
        if (grn > mx) mx = grn;
        if (blu > mx) mx = blu;
        if (grn < mn) mn = grn;
        if (blu < mn) mn = blu;
        d = mx - mn;
        val = round_half_even(mx * 100, 255);
        hue = 0;
        sat = 0;
        if (d > 0) begin
            sat = round_half_even(d * 100, mx);
            if (red == mx) begin
                num = 60 * (grn - blu);
            end else if (grn == mx) begin
                num = 60 * (2 * d + blu - red);
            end else begin
                num = 60 * (4 * d + red - grn);
            end
            if (num < 0) num += 360 * d;
            hue = round_half_even(num, d);
            if (hue >= 360) hue -= 360;
        end
        res.in_range = $signed(limits.hue_low) < hue && hue < int'(limits.hue_high) &&
                       $signed(limits.sat_low) < sat && sat < int'(limits.sat_high) &&
                       $signed(limits.val_low) < val && val < int'(limits.val_high);
        res.hue_deg = hue[HUE_W-1:0];
        res.sat_pct = sat[PCT_W-1:0];
        res.val_pct = val[PCT_W-1:0];
        return res;
    endfunction

    function automatic logic [3*COMP_W-1:0] random_pixel(input logic [3*COMP_W-1:0] center);
        int unsigned roll;
        int          base;
        int          ch;
        logic [3*COMP_W-1:0] pix;
        roll = $urandom_range(0, 99);
        base = $urandom_range(0, 255);
        for (int k = 0; k < 3; k++) begin
            if (roll < 40) begin
                ch = $urandom_range(0, 255);
            end else if (roll < 75) begin
                ch = int'(center[k*COMP_W +: COMP_W]) + int'($urandom_range(0, 12)) - 6;
            end else if (roll < 90) begin
                ch = ($urandom_range(0, 3) == 0) ? base + 1 : base;
            end else begin
                case ($urandom_range(0, 3))
                    0: ch = 0;
                    1: ch = 1;
                    2: ch = 254;
                    default: ch = 255;
                endcase
            end
            if (ch < 0) ch = 0;
            if (ch > 255) ch = 255;
            pix[k*COMP_W +: COMP_W] = ch[COMP_W-1:0];
        end
        return pix;
    endfunction

    function automatic int unsigned next_gap();
        int unsigned roll;
        if (tx_burst_left > 0) begin
            tx_burst_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            tx_burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 50) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int window_margin();
        return int'($urandom_range(0, 20));
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    // leaves the write enable high so writes can follow back to back
    task automatic write_bound(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_HUE_LOW:  limits.hue_low  = data[9:0];
            CFG_HUE_HIGH: limits.hue_high = data[8:0];
            CFG_SAT_LOW:  limits.sat_low  = data[7:0];
            CFG_SAT_HIGH: limits.sat_high = data[6:0];
            CFG_VAL_LOW:  limits.val_low  = data[7:0];
            CFG_VAL_HIGH: limits.val_high = data[6:0];
            default: ;
        endcase
    endtask

    task automatic program_bounds(input logic [CFG_W-1:0] hl, hh, sl, sh, vl, vh);
        write_bound(CFG_HUE_LOW,  hl);
        write_bound(CFG_HUE_HIGH, hh);
        write_bound(CFG_SAT_LOW,  sl);
        write_bound(CFG_SAT_HIGH, sh);
        write_bound(CFG_VAL_LOW,  vl);
        write_bound(CFG_VAL_HIGH, vh);
    endtask

    task automatic send_pixel(input logic [COMP_W-1:0] r, g, b, input bit typed,
                              input t_result typed_res, input bit steady);
        int unsigned gap;
        i_valid    <= 1'b1;
        i_red_in   <= r;
        i_green_in <= g;
        i_blue_in  <= b;
        do @(posedge i_clk); while (o_stall);
        pending_hsv.push_back(typed ? typed_res : pixel_to_hsv(r, g, b));
        gap = steady ? 0 : next_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // receiver back-pressure
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                i_stall <= 1'b0;
            end else begin
                if (rx_stall_left == 0 && rx_free_left == 0) begin
                    case ($urandom_range(0, 19))
                        0, 1:       rx_free_left = $urandom_range(20, 80);
                        2:          rx_stall_left = $urandom_range(8, 30);
                        3, 4, 5, 6: rx_stall_left = $urandom_range(1, 3);
                        default:    rx_free_left = $urandom_range(1, 4);
                    endcase
                end
                if (rx_stall_left > 0) begin
                    i_stall <= 1'b1;
                    rx_stall_left--;
                end else begin
                    i_stall <= 1'b0;
                    rx_free_left--;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        string   diff;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_hsv.size() == 0) begin
                flag_mismatch($sformatf("result with none pending, hue %0d", o_hue_deg));
            end else begin
                want = pending_hsv.pop_front();
                diff = "";
                if (o_in_range !== want.in_range)
                    diff = {diff, $sformatf(" in_range %0b/%0b", o_in_range, want.in_range)};
                if (o_hue_deg !== want.hue_deg)
                    diff = {diff, $sformatf(" hue %0d/%0d", o_hue_deg, want.hue_deg)};
                if (o_sat_pct !== want.sat_pct)
                    diff = {diff, $sformatf(" sat %0d/%0d", o_sat_pct, want.sat_pct)};
                if (o_val_pct !== want.val_pct)
                    diff = {diff, $sformatf(" val %0d/%0d", o_val_pct, want.val_pct)};
                if (diff != "") flag_mismatch({"got/exp", diff});
            end
        end
    end

    initial begin : stimulus
        logic [3*COMP_W-1:0] center;
        logic [3*COMP_W-1:0] pix;
        t_result             aim;
        int unsigned         waited;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[n]) begin
            send_pixel(directed_rows[n].red, directed_rows[n].green, directed_rows[n].blue,
                       directed_rows[n].typed, directed_rows[n].res, 1'b0);
        end

        foreach (plan[p]) begin
            // bounds change only with the pipeline empty
            i_valid <= 1'b0;
            while (pending_hsv.size() != 0) @(posedge i_clk);
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            center = 24'($urandom);
            aim = pixel_to_hsv(center[23:16], center[15:8], center[7:0]);
            case (plan[p])
                BND_OPEN: begin
                    program_bounds(10'h200, 10'h1FF, 10'h080, 10'h07F, 10'h080, 10'h07F);
                    write_bound(CFG_UNUSED_LO, 10'($urandom));
                    write_bound(CFG_UNUSED_HI, 10'($urandom));
                end
                BND_CLOSED: begin
                    program_bounds(10'h1FF, 10'h200, 10'h37F, 10'h380, 10'h37F, 10'h380);
                    hold_req = 1'b1;
                end
                BND_WINDOW: begin
                    program_bounds(CFG_W'(int'(aim.hue_deg) - window_margin()),
                                   {1'($urandom), 9'(int'(aim.hue_deg) + window_margin())},
                                   {2'($urandom), 8'(int'(aim.sat_pct) - window_margin())},
                                   {3'($urandom), 7'(int'(aim.sat_pct) + window_margin())},
                                   {2'($urandom), 8'(int'(aim.val_pct) - window_margin())},
                                   {3'($urandom), 7'(int'(aim.val_pct) + window_margin())});
                end
                BND_ANY: begin
                    program_bounds(10'($urandom), 10'($urandom), 10'($urandom),
                                   10'($urandom), 10'($urandom), 10'($urandom));
                end
                default: ;
            endcase
            i_cfg_wr_en <= 1'b0;
            repeat (PHASE_PIXELS) begin
                pix = random_pixel(center);
                send_pixel(pix[23:16], pix[15:8], pix[7:0], 1'b0, '0, plan[p] == BND_CLOSED);
            end
        end

        i_valid <= 1'b0;
        waited = 0;
        while (pending_hsv.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_hsv.size() != 0) begin
            flag_mismatch($sformatf("%0d results never arrived", pending_hsv.size()));
        end
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Verification failed");
        $finish;
    end

endmodule

>>> sim.f
sv/rhrt_pkg.sv
sv/rhrt_prep.sv
sv/rhrt_scale.sv
sv/rhrt_div_cell.sv
sv/rhrt_round.sv
sv/rgb_hsv_range_threshold_unit.sv
tb/tb.sv
